>>> rtl/erpy_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package erpy_pkg;
    localparam int ANGLE_WIDTH_DEF  = 16;
    localparam int ENTRY_WIDTH_DEF  = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int WORK_FRAC = 30;
    localparam int WW = 34;
    typedef logic signed [WW-1:0] work_t;
    localparam work_t PI_Q30      = 34'sd3373259426;
    localparam work_t HALF_PI_Q30 = 34'sd1686629713;
    localparam work_t GAIN_Q30    = 34'sd652032874;

    function automatic work_t atan_q30(input logic [4:0] i);
        work_t r;
        case (i)
            5'd0:  r = 34'sd843314857;
            5'd1:  r = 34'sd497837829;
            5'd2:  r = 34'sd263043837;
            5'd3:  r = 34'sd133525159;
            5'd4:  r = 34'sd67021687;
            5'd5:  r = 34'sd33543516;
            5'd6:  r = 34'sd16775851;
            5'd7:  r = 34'sd8388437;
            5'd8:  r = 34'sd4194283;
            5'd9:  r = 34'sd2097149;
            5'd31: r = 34'sd0;
            default: r = work_t'(34'sd1 <<< (5'd30 - i));
        endcase
        return r;
    endfunction

    // q4.30 product rounded half up back to q4.30
    function automatic work_t mulq(input work_t a, input work_t b);
        logic signed [2*WW-1:0] p;
        p = a * b + (68'sd1 <<< (WORK_FRAC - 1));
        return work_t'(p >>> WORK_FRAC);
    endfunction
endpackage
`default_nettype wire

>>> rtl/erpy_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface erpy_if #(parameter int W = 48);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/erpy_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// pipelined cordic for three angles at once, one step per stage
module erpy_cordic #(
    parameter int ANGLE_WIDTH  = erpy_pkg::ANGLE_WIDTH_DEF,
    parameter int CORDIC_STEPS = erpy_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            en,
    input  wire logic                            in_valid,
    input  wire logic signed [ANGLE_WIDTH-1:0]   ang [3],
    output logic                                 out_valid,
    output erpy_pkg::work_t                      sn [3],
    output erpy_pkg::work_t                      cs [3]
);
    localparam int N = CORDIC_STEPS;
    erpy_pkg::work_t x_reg [N+1][3];
    erpy_pkg::work_t y_reg [N+1][3];
    erpy_pkg::work_t z_reg [N+1][3];
    logic            f_reg [N+1][3];
    logic [N:0]      v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[N-1:0], in_valid};
        end
    end

    // fold stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                erpy_pkg::work_t z;
                z = erpy_pkg::work_t'(ang[k]) <<< (erpy_pkg::WORK_FRAC - (ANGLE_WIDTH - 3));
                x_reg[0][k] <= erpy_pkg::GAIN_Q30;
                y_reg[0][k] <= '0;
                if (z > erpy_pkg::HALF_PI_Q30)
                begin
                    z_reg[0][k] <= z - erpy_pkg::PI_Q30;
                    f_reg[0][k] <= 1'b1;
                end
                else if (z < -erpy_pkg::HALF_PI_Q30)
                begin
                    z_reg[0][k] <= z + erpy_pkg::PI_Q30;
                    f_reg[0][k] <= 1'b1;
                end
                else
                begin
                    z_reg[0][k] <= z;
                    f_reg[0][k] <= 1'b0;
                end
            end
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    f_reg[i+1][k] <= f_reg[i][k];
                    if (!z_reg[i][k][erpy_pkg::WW-1])
                    begin
                        x_reg[i+1][k] <= x_reg[i][k] - (y_reg[i][k] >>> i);
                        y_reg[i+1][k] <= y_reg[i][k] + (x_reg[i][k] >>> i);
                        z_reg[i+1][k] <= z_reg[i][k] - erpy_pkg::atan_q30(5'(i));
                    end
                    else
                    begin
                        x_reg[i+1][k] <= x_reg[i][k] + (y_reg[i][k] >>> i);
                        y_reg[i+1][k] <= y_reg[i][k] - (x_reg[i][k] >>> i);
                        z_reg[i+1][k] <= z_reg[i][k] + erpy_pkg::atan_q30(5'(i));
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sn[k] = f_reg[N][k] ? -y_reg[N][k] : y_reg[N][k];
            cs[k] = f_reg[N][k] ? -x_reg[N][k] : x_reg[N][k];
        end
    end
    assign out_valid = v_reg[N];
endmodule
`default_nettype wire

>>> rtl/erpy_matrix.sv
`timescale 1ns / 1ps
`default_nettype none
// product stages: inner products, outer products, sum and saturate
module erpy_matrix #(
    parameter int ENTRY_WIDTH = erpy_pkg::ENTRY_WIDTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire erpy_pkg::work_t             sn [3],
    input  wire erpy_pkg::work_t             cs [3],
    output logic                             out_valid,
    output logic [9*ENTRY_WIDTH-1:0]         entries
);
    localparam int EF = ENTRY_WIDTH - 2;
    localparam int SH = erpy_pkg::WORK_FRAC - EF;
    erpy_pkg::work_t s_reg [3];
    erpy_pkg::work_t c_reg [3];
    erpy_pkg::work_t spsr_reg, spcr_reg;
    erpy_pkg::work_t p_reg [9][2];
    logic [9*ENTRY_WIDTH-1:0] e_reg;
    logic [2:0] v_reg;

    function automatic logic [ENTRY_WIDTH-1:0] to_entry(input erpy_pkg::work_t v);
        erpy_pkg::work_t e;
        erpy_pkg::work_t lim;
        lim = erpy_pkg::work_t'(34'sd1 <<< EF);
        if (SH == 0)
            e = v;
        else
            e = (v + erpy_pkg::work_t'(34'sd1 <<< (SH - 1))) >>> SH;
        if (e > lim)
            e = lim;
        if (e < -lim)
            e = -lim;
        return e[ENTRY_WIDTH-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg    <= sn;
            c_reg    <= cs;
            spsr_reg <= erpy_pkg::mulq(sn[1], sn[0]);
            spcr_reg <= erpy_pkg::mulq(sn[1], cs[0]);
            // index 0 roll, 1 pitch, 2 yaw
            p_reg[0][0] <= erpy_pkg::mulq(c_reg[2], c_reg[1]);
            p_reg[0][1] <= '0;
            p_reg[1][0] <= erpy_pkg::mulq(c_reg[2], spsr_reg);
            p_reg[1][1] <= -erpy_pkg::mulq(s_reg[2], c_reg[0]);
            p_reg[2][0] <= erpy_pkg::mulq(c_reg[2], spcr_reg);
            p_reg[2][1] <= erpy_pkg::mulq(s_reg[2], s_reg[0]);
            p_reg[3][0] <= erpy_pkg::mulq(s_reg[2], c_reg[1]);
            p_reg[3][1] <= '0;
            p_reg[4][0] <= erpy_pkg::mulq(s_reg[2], spsr_reg);
            p_reg[4][1] <= erpy_pkg::mulq(c_reg[2], c_reg[0]);
            p_reg[5][0] <= erpy_pkg::mulq(s_reg[2], spcr_reg);
            p_reg[5][1] <= -erpy_pkg::mulq(c_reg[2], s_reg[0]);
            p_reg[6][0] <= -s_reg[1];
            p_reg[6][1] <= '0;
            p_reg[7][0] <= erpy_pkg::mulq(c_reg[1], s_reg[0]);
            p_reg[7][1] <= '0;
            p_reg[8][0] <= erpy_pkg::mulq(c_reg[1], c_reg[0]);
            p_reg[8][1] <= '0;
            for (int k = 0; k < 9; k++)
            begin
                e_reg[k*ENTRY_WIDTH +: ENTRY_WIDTH] <= to_entry(p_reg[k][0] + p_reg[k][1]);
            end
        end
    end
    assign entries   = e_reg;
    assign out_valid = v_reg[2];
endmodule
`default_nettype wire

>>> rtl/euler_rpy_to_rotation_matrix_unit.sv
`timescale 1ns / 1ps
// pipeline: CORDIC_STEPS + 4 register stages: fold, cordic steps, inputs, products, entries
// throughput: one request per cycle while the output is not stalled, set by the fully pipelined cordic steps
// a stall at the output freezes the whole pipeline, nothing lost or repeated
// reset clears all valid bits; datapath registers are not reset
`default_nettype none
module euler_rpy_to_rotation_matrix_unit #(
    parameter int ANGLE_WIDTH  = erpy_pkg::ANGLE_WIDTH_DEF,
    parameter int ENTRY_WIDTH  = erpy_pkg::ENTRY_WIDTH_DEF,
    parameter int CORDIC_STEPS = erpy_pkg::CORDIC_STEPS_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    erpy_if.sink     in_ch,
    erpy_if.source   out_ch
);
    logic en;
    logic cv, mv;
    logic signed [ANGLE_WIDTH-1:0] ang [3];
    erpy_pkg::work_t sn [3];
    erpy_pkg::work_t cs [3];
    logic [9*ENTRY_WIDTH-1:0] entries;

    assign en = out_ch.ready || !mv;
    assign in_ch.ready = en;
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ang[k] = in_ch.data[k*ANGLE_WIDTH +: ANGLE_WIDTH];
        end
    end

    erpy_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_ch.valid),
        .ang(ang), .out_valid(cv), .sn(sn), .cs(cs)
    );

    erpy_matrix #(.ENTRY_WIDTH(ENTRY_WIDTH)) u_matrix (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(cv),
        .sn(sn), .cs(cs), .out_valid(mv), .entries(entries)
    );

    assign out_ch.valid = mv;
    assign out_ch.data  = entries;
endmodule
`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    localparam int ANG_W     = erpy_pkg::ANGLE_WIDTH_DEF;
    localparam int ENT_W     = erpy_pkg::ENTRY_WIDTH_DEF;
    localparam int STEPS     = erpy_pkg::CORDIC_STEPS_DEF;
    localparam int LATENCY   = STEPS + 5;
    localparam int MAX_CYCLES = 400000;
    localparam longint PI_FX      = 64'sd3373259426;
    localparam longint HALF_PI_FX = 64'sd1686629713;
    localparam longint GAIN_FX    = 64'sd652032874;
    localparam longint ENT_LIM    = 64'sd1 <<< (ENT_W - 2);

    typedef logic signed [ANG_W-1:0] angle_t;
    typedef logic [9*ENT_W-1:0] matrix_t;

    logic clk;
    logic rst_n;
    int   cycle_count;
    int   fail_count;
    int   src_idle_pct;
    int   snk_idle_pct;
    matrix_t expected_matrices[$];
    longint  arctan_steps[32];
    string   entry_names[9] = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};

    erpy_if #(.W(3*ANG_W)) in_ch ();
    erpy_if #(.W(9*ENT_W)) out_ch ();

    euler_rpy_to_rotation_matrix_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        arctan_steps[0] = 843314857;
        arctan_steps[1] = 497837829;
        arctan_steps[2] = 263043837;
        arctan_steps[3] = 133525159;
        arctan_steps[4] = 67021687;
        arctan_steps[5] = 33543516;
        arctan_steps[6] = 16775851;
        arctan_steps[7] = 8388437;
        arctan_steps[8] = 4194283;
        arctan_steps[9] = 2097149;
        for (int i = 10; i < 31; i++)
            arctan_steps[i] = 64'sd1 <<< (30 - i);
        arctan_steps[31] = 0;
    end

    function automatic longint fx_mul(input longint a, input longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    // angle folded into +-pi/2, then rotated toward zero residual
    function automatic void angle_sin_cos(input angle_t ang, output longint sn,
                                          output longint cs);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        z = longint'(ang) * (64'sd1 <<< (30 - (ANG_W - 3)));
        x = GAIN_FX;
        y = 0;
        flip = 1'b0;
        if (z > HALF_PI_FX)
        begin
            z -= PI_FX;
            flip = 1'b1;
        end
        else if (z < -HALF_PI_FX)
        begin
            z += PI_FX;
            flip = 1'b1;
        end
        for (int i = 0; i < STEPS && i < 32; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= arctan_steps[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += arctan_steps[i];
            end
        end
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endfunction

    function automatic logic [ENT_W-1:0] to_entry(input longint v);
        longint e;
        e = (v + (64'sd1 <<< (30 - (ENT_W - 2) - 1))) >>> (30 - (ENT_W - 2));
        if (e > ENT_LIM)
            e = ENT_LIM;
        if (e < -ENT_LIM)
            e = -ENT_LIM;
        return e[ENT_W-1:0];
    endfunction

    function automatic matrix_t rotation_matrix(input angle_t roll, input angle_t pitch,
                                                input angle_t yaw);
        longint sr, cr, sp, cp, sy, cy, spsr, spcr;
        matrix_t m;
        angle_sin_cos(roll, sr, cr);
        angle_sin_cos(pitch, sp, cp);
        angle_sin_cos(yaw, sy, cy);
        spsr = fx_mul(sp, sr);
        spcr = fx_mul(sp, cr);
        m[0*ENT_W +: ENT_W] = to_entry(fx_mul(cy, cp));
        m[1*ENT_W +: ENT_W] = to_entry(fx_mul(cy, spsr) - fx_mul(sy, cr));
        m[2*ENT_W +: ENT_W] = to_entry(fx_mul(cy, spcr) + fx_mul(sy, sr));
        m[3*ENT_W +: ENT_W] = to_entry(fx_mul(sy, cp));
        m[4*ENT_W +: ENT_W] = to_entry(fx_mul(sy, spsr) + fx_mul(cy, cr));
        m[5*ENT_W +: ENT_W] = to_entry(fx_mul(sy, spcr) - fx_mul(cy, sr));
        m[6*ENT_W +: ENT_W] = to_entry(-sp);
        m[7*ENT_W +: ENT_W] = to_entry(fx_mul(cp, sr));
        m[8*ENT_W +: ENT_W] = to_entry(fx_mul(cp, cr));
        return m;
    endfunction

    task automatic send_pose(input angle_t roll, input angle_t pitch, input angle_t yaw);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= {yaw, pitch, roll};
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        expected_matrices.push_back(rotation_matrix(roll, pitch, yaw));
        @(negedge clk);
    endtask

    function automatic angle_t rand_angle();
        int r;
        r = $urandom_range(9);
        // bias some angles toward the fold points at +-pi/2
        if (r < 2)
            return angle_t'($signed(($urandom_range(1) ? 12868 : -12868)
                                    + $signed($urandom_range(8)) - 4));
        return angle_t'($urandom);
    endfunction

    task automatic wait_drained();
        while (expected_matrices.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_directed();
        angle_t corners[10] = '{16'sh7fff, -16'sh8000, 16'sd0, 16'sd12868, -16'sd12868,
                                16'sd12869, -16'sd12869, 16'sd25736, -16'sd25736, 16'sd1};
        for (int i = 0; i < 10; i++)
            send_pose(corners[i], corners[(i + 3) % 10], corners[(i + 7) % 10]);
        send_pose(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_pose(-16'sh8000, -16'sh8000, -16'sh8000);
        send_pose(16'sd0, 16'sd12868, 16'sd0);
        send_pose(16'sd0, -16'sd12868, 16'sd0);
        send_pose(16'sh5555, -16'sh5556, 16'sh2aaa);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
            send_pose(rand_angle(), rand_angle(), rand_angle());
    endtask

    task automatic test_pause_until_drained();
        in_ch.valid <= 1'b0;
        @(negedge clk);
        wait_drained();
        test_random(20);
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_matrices.size() == 0)
            begin
                $error("result with no request outstanding: %h", out_ch.data);
                fail_count++;
            end
            else
            begin
                matrix_t want;
                want = expected_matrices.pop_front();
                for (int k = 0; k < 9; k++)
                begin
                    if (out_ch.data[k*ENT_W +: ENT_W] !== want[k*ENT_W +: ENT_W])
                    begin
                        $error("%s expected %0d actual %0d", entry_names[k],
                               $signed(want[k*ENT_W +: ENT_W]),
                               $signed(out_ch.data[k*ENT_W +: ENT_W]));
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(negedge clk)
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        cycle_count  = 0;
        fail_count   = 0;
        src_idle_pct = 25;
        snk_idle_pct = 81;
        rst_n        = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(600);
        test_pause_until_drained();
        src_idle_pct = 81;
        snk_idle_pct = 25;
        test_random(600);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random(600);

        in_ch.valid <= 1'b0;
        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);
        if (fail_count == 0 && expected_matrices.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire

>>> sim.f
rtl/erpy_pkg.sv
rtl/erpy_if.sv
rtl/erpy_cordic.sv
rtl/erpy_matrix.sv
rtl/euler_rpy_to_rotation_matrix_unit.sv
verif/testbench.sv
